>>> rtl/cpst_pkg.sv
// Package for the crop phenology stage tracker.
// Holds field widths, phase and error codes, register indexes, the
// controller/datapath command and status structs and the saturating adder.
package cpst_pkg;

  // Field widths
  localparam int TEMP_W   = 14;
  localparam int STRESS_W = 17;
  localparam int DEPTH_W  = 8;
  localparam int DAY_W    = 16;
  localparam int SUM_W    = 32;
  localparam int BONUS_W  = 14;
  localparam int PHASE_W  = 3;
  localparam int ERR_W    = 2;
  localparam int DDT_W    = 15;
  localparam int THR_W    = 20;
  localparam int GAIN_W   = 16;
  localparam int GERM_W   = 18;
  localparam int EDAY_W   = 17;
  localparam int TGT_W    = 25;
  localparam int PROD1_W  = GAIN_W + TEMP_W;
  localparam int PROD2_W  = PROD1_W + STRESS_W;

  // Stream widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 136;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_AP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GERM_TT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TT_STAR       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TT_FLOWER     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TT_FLOWER_END = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TT_MATURITY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EMERGENCE_DAY = 3'd7;

  // Register reset values
  localparam logic [GERM_W-1:0] GERM_TT_RST       = 18'd22016;
  localparam logic [EDAY_W-1:0] EMERGENCE_DAY_RST = 17'h1FFFF;

  // Growth phases
  localparam logic [PHASE_W-1:0] PH_UNSOWN    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_GERM      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_JUVENILE  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ACTIVE    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FLOWER    = 3'd4;
  localparam logic [PHASE_W-1:0] PH_MATURE    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DRY       = 3'd6;
  localparam logic [PHASE_W-1:0] PH_HARVESTED = 3'd7;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_NO_SOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EARLY  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_UNUSED = 2'd3;

  // Fixed-point constants
  localparam logic [STRESS_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [SUM_W-1:0]    SUM_MAX = 32'hFFFF_FFFF;

  // Output tdata bit positions (low bit of each field)
  localparam int O_CHG_LSB  = 129;
  localparam int O_SDAY_LSB = 113;
  localparam int O_ERR_LSB  = 130;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch accepted input transaction
    logic step1;   // first multiply, total and flowering sums
    logic step2;   // second multiply, emergence sum
    logic commit;  // phase update, state write, result load
  } cpst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } cpst_status_t;

  // 32-bit add of a day's thermal time, saturating at all ones
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [DDT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W+1-DDT_W){1'b0}}, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

>>> rtl/cpst_ctrl.sv
// Controller of the crop phenology stage tracker.
// Sequences load, two multiply steps and commit; depends on cpst_pkg.
module cpst_ctrl
  import cpst_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  cpst_status_t status,
  output cpst_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.step1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.step2 = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // wait here while the previous result is still unread
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/cpst_dp.sv
// Datapath of the crop phenology stage tracker.
// Config registers, daily state, multipliers, sums and the result register;
// depends on cpst_pkg.
module cpst_dp
  import cpst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  cpst_cmd_t             cmd,
  output cpst_status_t          status,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Config registers
  logic [GAIN_W-1:0] ap_gain_r;
  logic [GERM_W-1:0] germ_tt_r;
  logic [GAIN_W-1:0] depth_rate_r;
  logic [THR_W-1:0]  tt_star_r, tt_flower_r, tt_flower_end_r, tt_maturity_r;
  logic [EDAY_W-1:0] emergence_day_r;

  // Daily state
  logic [PHASE_W-1:0]  phase_r;
  logic [SUM_W-1:0]    sum_total_r, sum_emerged_r, sum_flowering_r;
  logic [BONUS_W-1:0]  bonus_r;
  logic [STRESS_W-1:0] stress_prev_r;
  logic [SUM_W-1:0]    target_r;
  logic [DAY_W-1:0]    sow_day_r;

  // Latched input transaction
  logic [TEMP_W-1:0]   temp_r;
  logic [STRESS_W-1:0] stress_r;
  logic                sow_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic                harv_r;
  logic [DAY_W-1:0]    day_r;

  // Intermediate results
  logic [PROD1_W-1:0]         prod1_r;
  logic [GAIN_W+DEPTH_W-1:0]  tprod_r;
  logic [SUM_W-1:0]           tot_tmp_r, flw_tmp_r, emg_tmp_r;
  logic [BONUS_W-1:0]         bonus_tmp_r;
  logic [TGT_W-1:0]           tgt_tmp_r;
  logic                       emerge_hit_r;

  // Result register
  logic                  out_valid_r;
  logic [PHASE_W-1:0]    o_phase_r;
  logic [SUM_W-1:0]      o_total_r, o_emerged_r, o_flowering_r;
  logic [BONUS_W-1:0]    o_bonus_r;
  logic [DAY_W-1:0]      o_sday_r;
  logic                  o_chg_r;
  logic [ERR_W-1:0]      o_err_r;

  logic                  in_field, in_bloom, simulated;
  logic [DDT_W-1:0]      ddt;
  logic [PROD1_W-1:0]    prod1_nxt;
  logic [PROD2_W-1:0]    prod2_nxt;
  logic [STRESS_W-1:0]   factor;
  logic                  emg_cond, emerge_hit_nxt;
  logic [PHASE_W-1:0]    phase_nxt;
  logic                  chg_nxt;
  logic [ERR_W-1:0]      err_nxt;
  logic                  do_sow;

  assign in_field  = (phase_r != PH_UNSOWN) && (phase_r != PH_HARVESTED);
  assign in_bloom  = (phase_r == PH_FLOWER) || (phase_r == PH_MATURE) ||
                     (phase_r == PH_DRY);
  assign simulated = emergence_day_r[EDAY_W-1];
  assign ddt       = {1'b0, temp_r} + {{(DDT_W-BONUS_W){1'b0}}, bonus_r};
  assign do_sow    = (phase_r == PH_UNSOWN) && sow_r && !harv_r;

  // Bonus factor: one minus previous stress, zero when stress is one or more
  assign factor    = (stress_prev_r >= ONE_Q16) ? '0 : STRESS_W'(ONE_Q16 - stress_prev_r);
  assign prod1_nxt = {{(PROD1_W-GAIN_W){1'b0}}, ap_gain_r} *
                     {{(PROD1_W-TEMP_W){1'b0}}, temp_r};
  assign prod2_nxt = {{(PROD2_W-PROD1_W){1'b0}}, prod1_r} *
                     {{(PROD2_W-STRESS_W){1'b0}}, factor};

  // Emergence test on the new total sum (simulated) or on the day (forced)
  assign emg_cond       = simulated ? (tot_tmp_r >= target_r)
                                    : (emergence_day_r[DAY_W-1:0] <= day_r);
  assign emerge_hit_nxt = simulated ? (tot_tmp_r >= target_r)
                                    : (emergence_day_r[DAY_W-1:0] == day_r);

  // Phase transitions on sow, harvest, the emergence hit and the new emerged sum
  always_comb begin
    phase_nxt = phase_r;
    chg_nxt   = 1'b0;
    err_nxt   = ERR_NONE;
    unique case (phase_r)
      PH_UNSOWN: begin
        if (harv_r) err_nxt = ERR_NO_SOW;
        else if (sow_r) phase_nxt = PH_GERM;
      end
      PH_GERM: begin
        if (harv_r) begin
          phase_nxt = PH_HARVESTED;
          err_nxt   = ERR_EARLY;
        end else if (emerge_hit_r) begin
          phase_nxt = PH_JUVENILE;
        end
      end
      PH_JUVENILE: begin
        if (harv_r) begin
          phase_nxt = PH_HARVESTED;
          err_nxt   = ERR_EARLY;
        end else if (emg_tmp_r >= {{(SUM_W-THR_W){1'b0}}, tt_star_r}) begin
          phase_nxt = PH_ACTIVE;
          chg_nxt   = 1'b1;
        end
      end
      PH_ACTIVE: begin
        if (harv_r) begin
          phase_nxt = PH_HARVESTED;
          err_nxt   = ERR_EARLY;
        end else if (emg_tmp_r >= {{(SUM_W-THR_W){1'b0}}, tt_flower_r}) begin
          phase_nxt = PH_FLOWER;
          chg_nxt   = 1'b1;
        end
      end
      PH_FLOWER: begin
        if (harv_r) begin
          phase_nxt = PH_HARVESTED;
          err_nxt   = ERR_EARLY;
        end else if (emg_tmp_r >= {{(SUM_W-THR_W){1'b0}}, tt_flower_end_r}) begin
          phase_nxt = PH_MATURE;
          chg_nxt   = 1'b1;
        end
      end
      PH_MATURE: begin
        if (harv_r) begin
          phase_nxt = PH_HARVESTED;
        end else if (emg_tmp_r >= {{(SUM_W-THR_W){1'b0}}, tt_maturity_r}) begin
          phase_nxt = PH_DRY;
          chg_nxt   = 1'b1;
        end
      end
      PH_DRY: begin
        if (harv_r) phase_nxt = PH_HARVESTED;
      end
      PH_HARVESTED: phase_nxt = PH_HARVESTED;
      default: phase_nxt = phase_r;
    endcase
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_gain_r       <= '0;
      germ_tt_r       <= GERM_TT_RST;
      depth_rate_r    <= '0;
      tt_star_r       <= '0;
      tt_flower_r     <= '0;
      tt_flower_end_r <= '0;
      tt_maturity_r   <= '0;
      emergence_day_r <= EMERGENCE_DAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AP_GAIN:       ap_gain_r       <= cfg_wdata[GAIN_W-1:0];
        REG_GERM_TT:       germ_tt_r       <= cfg_wdata[GERM_W-1:0];
        REG_DEPTH_RATE:    depth_rate_r    <= cfg_wdata[GAIN_W-1:0];
        REG_TT_STAR:       tt_star_r       <= cfg_wdata[THR_W-1:0];
        REG_TT_FLOWER:     tt_flower_r     <= cfg_wdata[THR_W-1:0];
        REG_TT_FLOWER_END: tt_flower_end_r <= cfg_wdata[THR_W-1:0];
        REG_TT_MATURITY:   tt_maturity_r   <= cfg_wdata[THR_W-1:0];
        REG_EMERGENCE_DAY: emergence_day_r <= cfg_wdata[EDAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input latch and intermediate steps (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp_r   <= in_tdata[13:0];
      stress_r <= in_tdata[30:14];
      sow_r    <= in_tdata[31];
      depth_r  <= in_tdata[39:32];
      harv_r   <= in_tdata[40];
      day_r    <= in_tdata[56:41];
    end
    if (cmd.step1) begin
      prod1_r   <= prod1_nxt;
      tprod_r   <= {{DEPTH_W{1'b0}}, depth_rate_r} * {{GAIN_W{1'b0}}, depth_r};
      if (in_field && harv_r) tot_tmp_r <= '0;
      else if (in_field)      tot_tmp_r <= sat_add(sum_total_r, ddt);
      else                    tot_tmp_r <= sum_total_r;
      flw_tmp_r <= in_bloom ? sat_add(sum_flowering_r, ddt) : sum_flowering_r;
    end
    if (cmd.step2) begin
      bonus_tmp_r  <= prod2_nxt[SUM_W+BONUS_W-1:SUM_W];
      tgt_tmp_r    <= {{(TGT_W-GERM_W){1'b0}}, germ_tt_r} +
                      {{(TGT_W-GAIN_W-DEPTH_W){1'b0}}, tprod_r};
      emerge_hit_r <= emerge_hit_nxt;
      if (in_field && harv_r)     emg_tmp_r <= '0;
      else if (in_field && emg_cond) emg_tmp_r <= sat_add(sum_emerged_r, ddt);
      else                        emg_tmp_r <= sum_emerged_r;
    end
  end

  // Daily state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_UNSOWN;
      sum_total_r     <= '0;
      sum_emerged_r   <= '0;
      sum_flowering_r <= '0;
      bonus_r         <= '0;
      stress_prev_r   <= ONE_Q16;
      target_r        <= SUM_MAX;
      sow_day_r       <= '0;
    end else if (cmd.commit) begin
      phase_r         <= phase_nxt;
      sum_total_r     <= tot_tmp_r;
      sum_emerged_r   <= emg_tmp_r;
      sum_flowering_r <= flw_tmp_r;
      bonus_r         <= bonus_tmp_r;
      stress_prev_r   <= stress_r;
      if (do_sow) begin
        target_r  <= {{(SUM_W-TGT_W){1'b0}}, tgt_tmp_r};
        sow_day_r <= day_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_phase_r     <= phase_nxt;
      o_total_r     <= tot_tmp_r;
      o_emerged_r   <= emg_tmp_r;
      o_flowering_r <= flw_tmp_r;
      o_bonus_r     <= bonus_tmp_r;
      o_sday_r      <= chg_nxt ? DAY_W'(day_r - sow_day_r) : '0;
      o_chg_r       <= chg_nxt;
      o_err_r       <= err_nxt;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = {4'd0, o_err_r, o_chg_r, o_sday_r, o_bonus_r,
                            o_flowering_r, o_emerged_r, o_total_r, o_phase_r};

endmodule

>>> rtl/crop_phenology_stage_tracker.sv
// Crop phenology stage tracker, one transaction per simulated day.
// Input stream: in_tvalid/in_tready/in_tdata carries one day's weather and
// field events. Output stream: out_tvalid/out_tready/out_tdata carries the
// phase, the three saturating thermal-time sums, the bonus term, the stage
// day and the error code for that day. Registers are written through
// cfg_we/cfg_index/cfg_wdata only while the block is idle (a rule for the
// user; the block itself does not enforce it) and act from the next day. An
// accepted transaction passes through accept, two multiply steps through the
// bonus term multiplier chain and commit; its result shows on the output the
// cycle after commit. A new day is accepted only after the last one commits.
// The result register decouples the sides: the next day is accepted and
// worked on while a result waits; it then holds in the commit step until the
// receiver takes the earlier result.
// Reset (rst_n low, synchronous) restores the register defaults, puts the
// crop in the unsown phase, clears the sums and drops out_tvalid.
// Depends on cpst_pkg, cpst_ctrl and cpst_dp.
module crop_phenology_stage_tracker
  import cpst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // temp_eff[13:0], water_stress[30:14], sow_now[31], sow_depth[39:32],
  // harvest_now[40], day_index[56:41], zero pad [63:57]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // phase[2:0], tt_total[34:3], tt_emerged[66:35], tt_flowering[98:67],
  // bonus_term[112:99], stage_day[128:113], stage_changed[129],
  // error_code[131:130], zero pad [135:132]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cpst_cmd_t    cmd;
  cpst_status_t status;

  cpst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cpst_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // one day in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("transaction accepted while previous one in flight");

  // error code never takes the unused value
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[O_ERR_LSB+ERR_W-1:O_ERR_LSB] != ERR_UNUSED))
    else $error("unused error code on output");

  // stage day is zero unless a dated stage was reached
  a_stage_day: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[O_CHG_LSB]) |->
      (out_tdata[O_SDAY_LSB+DAY_W-1:O_SDAY_LSB] == '0))
    else $error("stage day set without stage change");
`endif

endmodule
